### src/utd_pkg.sv
// Shared types and constants for the UTF-8 to UTF-16 decoder.
// Used by utd_front, utd_queue, utd_back and utf8_to_utf16_decoder.
package utd_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int CNT_W = (COUNT_WIDTH < 16) ? COUNT_WIDTH : 16;
  localparam logic [CNT_W-1:0] CNT_LIMIT = '1;

  localparam logic [31:0] SURR_BASE = 32'h0001_0000;
  localparam logic [31:0] RANGE_END = 32'h0011_0000;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_STRAY = 2'd1,
    ST_RANGE = 2'd2,
    ST_TRUNC = 2'd3
  } utd_status_e;

  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        pair;
    logic        has_unit;
    logic        last;
    utd_status_e status;
  } utd_entry_t;

endpackage

### src/utd_front.sv
// Front end: accepts bytes, tracks the multi-byte sequence and classifies
// each byte into a queue entry. Depends on utd_pkg.
module utd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  input  logic                q_full_i,
  output logic                push_o,
  output utd_pkg::utd_entry_t entry_o
);
  import utd_pkg::*;

  logic        halted_q, halted_d;
  logic [2:0]  pend_q, pend_d;
  logic [31:0] acc_q, acc_d;
  utd_status_e err_q, err_d;

  logic        accept;
  logic        fin;
  logic [31:0] fin_val;
  logic [31:0] acc_sh;
  logic [31:0] sv;
  logic [2:0]  pend_dec;
  logic        has_unit, pair;
  logic [15:0] u0, u1;
  utd_status_e st;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = q_full_i;
  assign acc_sh     = {acc_q[25:0], data_byte_i[5:0]};
  assign pend_dec   = pend_q - 3'd1;
  assign sv         = fin_val - SURR_BASE;

  always_comb begin
    halted_d = halted_q;
    pend_d   = pend_q;
    acc_d    = acc_q;
    err_d    = err_q;
    fin      = 1'b0;
    fin_val  = acc_q;
    has_unit = 1'b0;
    pair     = 1'b0;
    u0       = 16'h0000;
    u1       = 16'h0000;
    if (!halted_q) begin
      if (pend_q == 3'd0) begin
        if (data_byte_i == 8'h00) begin
          halted_d = 1'b1;
          err_d    = ST_TRUNC;
        end else if (!data_byte_i[7]) begin
          has_unit = 1'b1;
          u0       = {8'h00, data_byte_i};
        end else if (!data_byte_i[6]) begin
          halted_d = 1'b1;
          err_d    = ST_STRAY;
        end else if (!data_byte_i[5]) begin
          pend_d = 3'd1;
          acc_d  = {27'd0, data_byte_i[4:0]};
        end else if (!data_byte_i[4]) begin
          pend_d = 3'd2;
          acc_d  = {28'd0, data_byte_i[3:0]};
        end else if (!data_byte_i[3]) begin
          pend_d = 3'd3;
          acc_d  = {29'd0, data_byte_i[2:0]};
        end else if (!data_byte_i[2]) begin
          pend_d = 3'd4;
          acc_d  = {30'd0, data_byte_i[1:0]};
        end else begin
          pend_d = 3'd5;
          acc_d  = {30'd0, data_byte_i[1:0]};
        end
      end else begin
        if (data_byte_i == 8'h00) begin
          halted_d = 1'b1;
          err_d    = ST_TRUNC;
          pend_d   = 3'd0;
        end else if (data_byte_i[7:6] == 2'b10) begin
          acc_d   = acc_sh;
          pend_d  = pend_dec;
          fin     = (pend_dec == 3'd0);
          fin_val = acc_sh;
        end else begin
          pend_d = 3'd0;
          fin    = 1'b1;
        end
      end
    end
    if (fin) begin
      if (fin_val < SURR_BASE) begin
        has_unit = 1'b1;
        u0       = fin_val[15:0];
      end else if (fin_val >= RANGE_END) begin
        halted_d = 1'b1;
        err_d    = ST_RANGE;
      end else begin
        has_unit = 1'b1;
        pair     = 1'b1;
        u0       = HI_SURR + {6'd0, sv[19:10]};
        u1       = LO_SURR + {6'd0, sv[9:0]};
      end
    end
    st = err_d;
    if (!halted_d && pend_d != 3'd0) begin
      st = ST_TRUNC;
    end
    if (last_byte_i) begin
      halted_d = 1'b0;
      pend_d   = 3'd0;
      acc_d    = 32'd0;
      err_d    = ST_OK;
    end
  end

  always_comb begin
    entry_o.unit0    = u0;
    entry_o.unit1    = u1;
    entry_o.pair     = pair;
    entry_o.has_unit = has_unit;
    entry_o.last     = last_byte_i;
    entry_o.status   = st;
    push_o           = accept && (has_unit || last_byte_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      halted_q <= 1'b0;
      pend_q   <= 3'd0;
      acc_q    <= 32'd0;
      err_q    <= ST_OK;
    end else if (accept) begin
      halted_q <= halted_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      err_q    <= err_d;
    end
  end

endmodule

### src/utd_queue.sv
// Two-entry queue between the front and back ends.
// Depends on utd_pkg for the entry type.
module utd_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  utd_pkg::utd_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output utd_pkg::utd_entry_t entry_o
);
  import utd_pkg::*;

  utd_entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

endmodule

### src/utd_back.sv
// Back end: expands queue entries into one or two result transfers,
// keeps the saturating unit count. Depends on utd_pkg.
module utd_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  utd_pkg::utd_entry_t q_entry_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [15:0]         code_unit_o,
  output logic                unit_valid_o,
  output logic                end_of_string_o,
  output logic [15:0]         units_total_o,
  output logic [1:0]          status_o
);
  import utd_pkg::*;

  logic             out_valid_q;
  logic [15:0]      code_q;
  logic             uvalid_q;
  logic             eos_q;
  logic [15:0]      total_q;
  utd_status_e      status_q;
  logic             beat_q, beat_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic             load, emit, final_beat, eos;

  assign load       = !out_valid_q || !out_stall_i;
  assign emit       = load && q_valid_i;
  assign final_beat = !(q_entry_i.pair && !beat_q);
  assign eos        = q_entry_i.last && final_beat;
  assign pop_o      = emit && final_beat;

  always_comb begin
    cnt_inc = cnt_q;
    if (q_entry_i.has_unit && cnt_q != CNT_LIMIT) begin
      cnt_inc = cnt_q + CNT_W'(1);
    end
    cnt_d  = cnt_q;
    beat_d = beat_q;
    if (emit) begin
      cnt_d  = eos ? '0 : cnt_inc;
      beat_d = !final_beat;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      beat_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      beat_q <= beat_d;
      cnt_q  <= cnt_d;
      if (load) begin
        out_valid_q <= q_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      code_q   <= beat_q ? q_entry_i.unit1 : q_entry_i.unit0;
      uvalid_q <= q_entry_i.has_unit;
      eos_q    <= eos;
      total_q  <= 16'(cnt_inc);
      status_q <= eos ? q_entry_i.status : ST_OK;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign code_unit_o     = code_q;
  assign unit_valid_o    = uvalid_q;
  assign end_of_string_o = eos_q;
  assign units_total_o   = total_q;
  assign status_o        = status_q;

`ifndef NO_ASSERTIONS
  a_second_beat_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q |-> q_valid_i && q_entry_i.pair)
    else $error("second surrogate beat without its entry");
  a_bare_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !unit_valid_o |-> end_of_string_o)
    else $error("unit-less result that is not the end mark");
  a_status_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> end_of_string_o)
    else $error("error status on a non-final result");
  a_count_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_string_o |-> cnt_q == '0)
    else $error("unit count not cleared after end of string");
`endif

endmodule

### src/utf8_to_utf16_decoder.sv
// Top level of the UTF-8 to UTF-16 decoder: front end, queue, back end.
// Depends on utd_pkg, utd_front, utd_queue and utd_back.
//
// Takes one UTF-8 byte per transfer and delivers UTF-16 code units. A byte
// is taken every cycle while the two-entry queue between the front end
// (sequence decode) and the back end (result output) has room. Each byte
// causes zero, one or two results; a code point from 0x10000 to 0x10FFFF
// gives a surrogate pair, which the back end sends as two results, the high
// surrogate first. The final byte of a string always yields one result
// flagged end_of_string, carrying the status and the saturating unit count,
// and clears all state for the next string. A result is registered in the
// queue and then in the back end's output register before it is valid.
module utf8_to_utf16_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] code_unit_o,
  output logic        unit_valid_o,
  output logic        end_of_string_o,
  output logic [15:0] units_total_o,
  output logic [1:0]  status_o
);
  import utd_pkg::*;

  utd_entry_t push_entry, head_entry;
  logic       push, q_full, q_valid, pop;

  utd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  utd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .entry_o (head_entry)
  );

  utd_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .code_unit_o     (code_unit_o),
    .unit_valid_o    (unit_valid_o),
    .end_of_string_o (end_of_string_o),
    .units_total_o   (units_total_o),
    .status_o        (status_o)
  );

endmodule
